[sv/odo_pkg.sv]
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [17:0]        LIN_GAIN_RST = 18'd24273;
  localparam logic [17:0]        ANG_GAIN_RST = 18'd32768;
  localparam logic signed [31:0] START_X_RST  = -32'sd93717;
  localparam logic signed [31:0] START_Y_RST  = -32'sd24310;
  localparam logic [31:0]        START_HD_RST = 32'd6865658;

  // cordic seed, q1.30 gain compensation
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

  // microseconds per second and half of it for rounding
  localparam logic [20:0] MICRO      = 21'd1000000;
  localparam logic [58:0] HALF_MICRO = 59'd500000;

  // ceil(2^52 / 10^6), exact quotient for any 32-bit dividend
  localparam logic [32:0] RECIP_MICRO = 33'd4503599628;

  // radians to binary angle per microsecond, scaled by 2^32
  localparam logic [41:0] HEAD_SCALE = 42'd2935890503282;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LIN_GAIN = 3'd0,
    REG_ANG_GAIN = 3'd1,
    REG_START_X  = 3'd2,
    REG_START_Y  = 3'd3,
    REG_START_HD = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] raw_lin_x;
    logic signed [31:0] raw_lin_y;
    logic signed [31:0] raw_ang_z;
    logic [23:0]        elapsed_time;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] quat_z;
    logic [30:0]        quat_w;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_ang;
  } odo_out_t;

  // arctangent of 2^-i as binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

[sv/planar_odometry_integrator_top.sv]
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_ready    | odo_in_t: raw_lin_x, raw_lin_y, raw_ang_z, dt
// out_    | output    | out_valid / out_ready  | odo_out_t: pose, quaternion, velocities
// cfg_    | input     | cfg_we, cfg_addr       | cfg_wdata, no wait, no read-back
//
// the result is loaded after the input item is taken and the next item can be taken
// only after that load; the work is two passes of the shared cordic rotator,
// two divides by 10^6 in five 12-bit reciprocal digits each and four heading
// partial products on the shared 35x35 multiplier
// in_ready is high only in idle; a finished item sits in the output register and
// the next item is accepted while it waits; a new result waits for out_ready
// reset is synchronous and active low and loads the gains and the start pose
module planar_odometry_integrator_top #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  odo_pkg::odo_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output odo_pkg::odo_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [odo_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [odo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import odo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [2:0] DIV_LAST = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE, S_VX, S_VX_W, S_VA, S_VA_W, S_CINIT, S_COR, S_COR_FIN,
    S_RM1, S_RM2, S_RACC, S_RND, S_PDT, S_DIV_INIT, S_DIV_MUL, S_DIV, S_POSE,
    S_HMUL, S_HMAG, S_HPP, S_HACC, S_HEAD, S_OUT
  } state_t;

  state_t state_r;

  // configuration and pose
  logic [17:0]        lin_gain_r, ang_gain_r;
  logic signed [31:0] pose_x_r, pose_y_r;
  logic [31:0]        pose_hd_r;

  // datapath
  odo_in_t            in_r;
  logic signed [31:0] vx_r, va_r, cos_r, sin_r;
  logic signed [69:0] prod_r;
  logic signed [65:0] acc_r;
  logic signed [33:0] rate_r;
  logic               axis_r, pass_r, dneg_r, hneg_r;
  logic [19:0]        rem_r;
  logic [59:0]        dvd_r;
  logic [2:0]         dcnt_r;
  logic [55:0]        hmag_r;
  logic [97:0]        hacc_r;
  logic [1:0]         hk_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [CNT_W-1:0]   ci_r;
  logic [1:0]         cq_r;

  logic               out_valid_r;
  odo_out_t           out_data_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // current divide digit: remainder so far and the next 12 dividend bits
  logic [31:0] div_cur;
  assign div_cur = {rem_r, dvd_r[59:48]};

  // shared multiplier operand selection
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_VX: begin
        mul_a = 35'(in_r.raw_lin_x);
        mul_b = {17'd0, lin_gain_r};
      end
      S_VA: begin
        mul_a = 35'(in_r.raw_ang_z);
        mul_b = {17'd0, ang_gain_r};
      end
      S_RM1: begin
        mul_a = 35'(vx_r);
        mul_b = axis_r ? 35'(sin_r) : 35'(cos_r);
      end
      S_RM2: begin
        mul_a = 35'(in_r.raw_lin_y);
        mul_b = axis_r ? 35'(cos_r) : 35'(sin_r);
      end
      S_PDT: begin
        mul_a = 35'(rate_r);
        mul_b = {11'd0, in_r.elapsed_time};
      end
      S_DIV_MUL: begin
        mul_a = {3'd0, div_cur};
        mul_b = {2'd0, RECIP_MICRO};
      end
      S_HMUL: begin
        mul_a = 35'(va_r);
        mul_b = {11'd0, in_r.elapsed_time};
      end
      S_HPP: begin
        mul_a = {7'd0, (hk_r[1] ? hmag_r[55:28] : hmag_r[27:0])};
        mul_b = {14'd0, (hk_r[0] ? HEAD_SCALE[41:21] : HEAD_SCALE[20:0])};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // gain rounding and saturation of the registered product
  logic signed [69:0] gain_rnd;
  logic signed [31:0] gain_sat;

  always_comb begin
    gain_rnd = (prod_r + 70'sd32768) >>> 16;
    if (gain_rnd > 70'sd2147483647)       gain_sat = 32'sh7fffffff;
    else if (gain_rnd < -70'sd2147483648) gain_sat = 32'sh80000000;
    else                                   gain_sat = gain_rnd[31:0];
  end

  // cordic rotator step and quadrant fold
  logic [31:0]        cor_ang, cor_qsum, cor_res;
  logic signed [33:0] csx, csy, mc, ms;
  logic signed [32:0] cat;
  logic signed [31:0] cc_q, cs_q;

  function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30)       r = ONE_Q30[31:0];
    else if (v < -ONE_Q30) r = -ONE_Q30[31:0];
    else                   r = v[31:0];
    return r;
  endfunction

  always_comb begin
    cor_ang  = pass_r ? {1'b0, pose_hd_r[31:1]} : pose_hd_r;
    cor_qsum = cor_ang + 32'h2000_0000;
    cor_res  = cor_ang - {cor_qsum[31:30], 30'd0};
    csx = cx_r >>> ci_r;
    csy = cy_r >>> ci_r;
    cat = {1'b0, atan_bam(5'(ci_r))};
    case (cq_r)
      2'd0: begin mc = cx_r;  ms = cy_r;  end
      2'd1: begin mc = -cy_r; ms = cx_r;  end
      2'd2: begin mc = -cx_r; ms = -cy_r; end
      default: begin mc = cy_r; ms = -cx_r; end
    endcase
    cc_q = clamp30(mc);
    cs_q = clamp30(ms);
  end

  // divide digit, pose update and heading update
  logic [11:0]        div_q;
  logic [31:0]        div_sub, div_rem;
  logic signed [69:0] prod_abs;
  logic signed [60:0] pose_sum, dq;
  logic signed [31:0] pose_sat, pose_old;
  logic [97:0]        hpp, hrnd;
  logic [31:0]        hdelta;

  always_comb begin
    div_q    = prod_r[63:52];
    div_sub  = {20'd0, div_q} * {11'd0, MICRO};
    div_rem  = div_cur - div_sub;
    prod_abs = (prod_r < 0) ? -prod_r : prod_r;
    dq       = dneg_r ? -61'($signed({1'b0, dvd_r})) : 61'($signed({1'b0, dvd_r}));
    pose_old = axis_r ? pose_y_r : pose_x_r;
    pose_sum = 61'(pose_old) + dq;
    if (pose_sum > 61'sd2147483647)       pose_sat = 32'sh7fffffff;
    else if (pose_sum < -61'sd2147483648) pose_sat = 32'sh80000000;
    else                                   pose_sat = pose_sum[31:0];
    case (hk_r)
      2'd0:    hpp = {49'd0, prod_r[48:0]};
      2'd1:    hpp = {28'd0, prod_r[48:0], 21'd0};
      2'd2:    hpp = {21'd0, prod_r[48:0], 28'd0};
      default: hpp = {prod_r[48:0], 49'd0};
    endcase
    hrnd   = hacc_r + (98'd1 << 47);
    hdelta = hrnd[79:48];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lin_gain_r  <= LIN_GAIN_RST;
      ang_gain_r  <= ANG_GAIN_RST;
      pose_x_r    <= START_X_RST;
      pose_y_r    <= START_Y_RST;
      pose_hd_r   <= START_HD_RST;
      axis_r      <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;

      // start registers also preset the pose
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_LIN_GAIN: lin_gain_r <= cfg_wdata[17:0];
          REG_ANG_GAIN: ang_gain_r <= cfg_wdata[17:0];
          REG_START_X:  pose_x_r   <= cfg_wdata;
          REG_START_Y:  pose_y_r   <= cfg_wdata;
          REG_START_HD: pose_hd_r  <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            axis_r  <= 1'b0;
            pass_r  <= 1'b0;
            state_r <= S_VX;
          end
        end
        S_VX: begin
          prod_r  <= mul_p;
          state_r <= S_VX_W;
        end
        S_VX_W: begin
          vx_r    <= gain_sat;
          state_r <= S_VA;
        end
        S_VA: begin
          prod_r  <= mul_p;
          state_r <= S_VA_W;
        end
        S_VA_W: begin
          va_r    <= gain_sat;
          state_r <= S_CINIT;
        end
        S_CINIT: begin
          cq_r    <= cor_qsum[31:30];
          cz_r    <= 33'(signed'(cor_res));
          cx_r    <= CORDIC_START;
          cy_r    <= '0;
          ci_r    <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          if (!cz_r[32]) begin
            cx_r <= cx_r - csy;
            cy_r <= cy_r + csx;
            cz_r <= cz_r - cat;
          end else begin
            cx_r <= cx_r + csy;
            cy_r <= cy_r - csx;
            cz_r <= cz_r + cat;
          end
          ci_r <= ci_r + 1'b1;
          if (ci_r == LAST_STEP) state_r <= S_COR_FIN;
        end
        S_COR_FIN: begin
          cos_r   <= cc_q;
          sin_r   <= cs_q;
          state_r <= pass_r ? S_OUT : S_RM1;
        end
        // rotated rate for the current axis
        S_RM1: begin
          prod_r  <= mul_p;
          state_r <= S_RM2;
        end
        S_RM2: begin
          acc_r   <= prod_r[65:0];
          prod_r  <= mul_p;
          state_r <= S_RACC;
        end
        S_RACC: begin
          acc_r   <= axis_r ? acc_r + prod_r[65:0] : acc_r - prod_r[65:0];
          state_r <= S_RND;
        end
        S_RND: begin
          rate_r  <= 34'((acc_r + 66'sd536870912) >>> 30);
          state_r <= S_PDT;
        end
        S_PDT: begin
          prod_r  <= mul_p;
          state_r <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          dneg_r  <= prod_r[69];
          dvd_r   <= 60'(prod_abs[58:0]) + 60'(HALF_MICRO);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV_MUL;
        end
        // divide by 10^6, 12 quotient bits per reciprocal multiply
        S_DIV_MUL: begin
          prod_r  <= mul_p;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r   <= div_rem[19:0];
          dvd_r   <= {dvd_r[47:0], div_q};
          dcnt_r  <= dcnt_r + 3'd1;
          state_r <= (dcnt_r == DIV_LAST) ? S_POSE : S_DIV_MUL;
        end
        S_POSE: begin
          if (axis_r) begin
            pose_y_r <= pose_sat;
            state_r  <= S_HMUL;
          end else begin
            pose_x_r <= pose_sat;
            axis_r   <= 1'b1;
            state_r  <= S_RM1;
          end
        end
        // heading delta: |va*dt| times scale in four partial products
        S_HMUL: begin
          prod_r  <= mul_p;
          state_r <= S_HMAG;
        end
        S_HMAG: begin
          hneg_r  <= prod_r[69];
          hmag_r  <= prod_abs[55:0];
          hacc_r  <= '0;
          hk_r    <= '0;
          state_r <= S_HPP;
        end
        S_HPP: begin
          prod_r  <= mul_p;
          state_r <= S_HACC;
        end
        S_HACC: begin
          hacc_r <= hacc_r + hpp;
          hk_r   <= hk_r + 2'd1;
          state_r <= (hk_r == 2'd3) ? S_HEAD : S_HPP;
        end
        S_HEAD: begin
          pose_hd_r <= hneg_r ? pose_hd_r - hdelta : pose_hd_r + hdelta;
          pass_r    <= 1'b1;
          state_r   <= S_CINIT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_data_r.pos_x    <= pose_x_r;
            out_data_r.pos_y    <= pose_y_r;
            out_data_r.heading  <= pose_hd_r;
            out_data_r.quat_z   <= cos_r[31] ? -sin_r : sin_r;
            out_data_r.quat_w   <= cos_r[31] ? 31'(-cos_r) : cos_r[30:0];
            out_data_r.vel_x    <= vx_r;
            out_data_r.vel_y    <= in_r.raw_lin_y;
            out_data_r.vel_ang  <= va_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import odo_pkg::*;

  localparam int STEPS       = CORDIC_STEPS_DEF;
  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN_WAIT  = 400;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint SEED_X  = 64'sd652032874;
  localparam logic [63:0] RAD_TO_BAM = 64'd2935890503282;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  odo_in_t in_data;
  logic out_valid;
  logic out_ready;
  odo_out_t out_data;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  planar_odometry_integrator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow of the configuration and the kept pose
  logic [17:0] lin_gain_q, ang_gain_q;
  longint pose_x_q, pose_y_q;
  logic [31:0] pose_hd_q;

  odo_in_t  sample_queue[$];
  odo_out_t pose_expect_q[$];

  int  fail_count;
  int  idle_cycles;
  bit  hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint clip_q30(longint v);
    if (v > Q30_ONE) return Q30_ONE;
    if (v < -Q30_ONE) return -Q30_ONE;
    return v;
  endfunction

  function automatic longint gain_scale(longint raw, logic [17:0] g);
    return clip32(floor_shr(raw * longint'(g) + 64'sd32768, 16));
  endfunction

  // microsecond product to seconds, half away from zero
  function automatic longint micro_round(longint v);
    if (v >= 0) return (v + 500000) / 1000000;
    return -((-v + 500000) / 1000000);
  endfunction

  function automatic logic [31:0] atan_tab(int i);
    logic [31:0] t[32] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
      32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
    return t[i];
  endfunction

  // cordic rotation mode on a binary angle, with quarter-turn folding
  task automatic bam_sincos(input logic [31:0] ang, output longint c, output longint s);
    logic [1:0]  quad;
    logic [31:0] resid;
    longint x, y, z, nx, a;
    quad  = 2'((ang + 32'h20000000) >> 30);
    resid = ang - {quad, 30'd0};
    z = longint'(signed'(resid));
    x = SEED_X;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      a = longint'(atan_tab(i));
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y  = y + floor_shr(x, i);
        z  = z - a;
      end else begin
        nx = x + floor_shr(y, i);
        y  = y - floor_shr(x, i);
        z  = z + a;
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c = clip_q30(c);
    s = clip_q30(s);
  endtask

  // one dead-reckoning step on the shadow pose
  task automatic integrate_sample(input odo_in_t smp);
    longint vx, vy, va, dt, c, s, rate, p, qz, qw;
    logic [127:0] prod;
    logic [63:0]  mag;
    logic [31:0]  dh;
    odo_out_t r;
    dt = longint'(smp.elapsed_time);
    vx = gain_scale(longint'(smp.raw_lin_x), lin_gain_q);
    vy = longint'(smp.raw_lin_y);
    va = gain_scale(longint'(smp.raw_ang_z), ang_gain_q);
    bam_sincos(pose_hd_q, c, s);
    rate = floor_shr(vx * c - vy * s + (64'sd1 <<< 29), 30);
    pose_x_q = clip32(pose_x_q + micro_round(rate * dt));
    rate = floor_shr(vx * s + vy * c + (64'sd1 <<< 29), 30);
    pose_y_q = clip32(pose_y_q + micro_round(rate * dt));
    p = va * dt;
    mag = (p < 0) ? 64'(-p) : 64'(p);
    prod = {64'd0, mag} * {64'd0, RAD_TO_BAM} + (128'd1 << 47);
    dh = prod[79:48];
    if (p < 0) dh = -dh;
    pose_hd_q = pose_hd_q + dh;
    bam_sincos({1'b0, pose_hd_q[31:1]}, qw, qz);
    if (qw < 0) begin
      qw = -qw;
      qz = -qz;
    end
    r.pos_x   = 32'(pose_x_q);
    r.pos_y   = 32'(pose_y_q);
    r.heading = pose_hd_q;
    r.quat_z  = 32'(qz);
    r.quat_w  = 31'(qw);
    r.vel_x   = 32'(vx);
    r.vel_y   = 32'(vy);
    r.vel_ang = 32'(va);
    pose_expect_q.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LIN_GAIN: lin_gain_q = val[17:0];
      REG_ANG_GAIN: ang_gain_q = val[17:0];
      REG_START_X:  pose_x_q = longint'(signed'(val));
      REG_START_Y:  pose_y_q = longint'(signed'(val));
      REG_START_HD: pose_hd_q = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'(signed'($urandom_range(0, 400000)) - 200000);
      3: return 32'(signed'($urandom_range(0, 8000000)) - 4000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic odo_in_t rand_sample();
    odo_in_t s;
    s.raw_lin_x = rand_word();
    s.raw_lin_y = rand_word();
    s.raw_ang_z = rand_word();
    case ($urandom_range(0, 4))
      0: s.elapsed_time = 24'(0);
      1: s.elapsed_time = 24'hFFFFFF;
      2: s.elapsed_time = 24'($urandom);
      default: s.elapsed_time = 24'($urandom_range(1000, 20000));
    endcase
    return s;
  endfunction

  task automatic queue_sample(input odo_in_t s);
    sample_queue.push_back(s);
    integrate_sample(s);
  endtask

  // wait until every queued item was taken and every result came back
  task automatic drain();
    while (sample_queue.size() != 0 || pose_expect_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // in_ready seen at negedge no longer tells whether the item was taken,
  // so acceptance is tracked at posedge and valid is released at the next negedge
  bit in_taken;
  always @(posedge clk) in_taken <= rst_n && in_valid && in_ready;

  // driver: offers queued items with random gaps
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the item until it is taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sample_queue.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= sample_queue.pop_front();
      if ($urandom_range(0, 2) == 0)
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(0, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stalls: random gaps plus one long hold-off on request
  int stall_left;
  int hold_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_off_req && hold_left == 0) begin
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 400)
                                                  : $urandom_range(1, 4);
    end
  end

  // monitor: compare each result with the oldest expectation
  odo_out_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pose_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = pose_expect_q.pop_front();
        if (out_data.pos_x !== want.pos_x)
          $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, out_data.pos_x);
        if (out_data.pos_y !== want.pos_y)
          $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, out_data.pos_y);
        if (out_data.heading !== want.heading)
          $display("%0t: heading expected %h actual %h", $time, want.heading,
                   out_data.heading);
        if (out_data.quat_z !== want.quat_z)
          $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z,
                   out_data.quat_z);
        if (out_data.quat_w !== want.quat_w)
          $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w,
                   out_data.quat_w);
        if (out_data.vel_x !== want.vel_x)
          $display("%0t: vel_x expected %0d actual %0d", $time, want.vel_x, out_data.vel_x);
        if (out_data.vel_y !== want.vel_y)
          $display("%0t: vel_y expected %0d actual %0d", $time, want.vel_y, out_data.vel_y);
        if (out_data.vel_ang !== want.vel_ang)
          $display("%0t: vel_ang expected %0d actual %0d", $time, want.vel_ang,
                   out_data.vel_ang);
        if (out_data !== want) fail_count++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  odo_in_t d;
  initial begin
    hold_off_req = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    lin_gain_q = LIN_GAIN_RST;
    ang_gain_q = ANG_GAIN_RST;
    pose_x_q   = longint'(START_X_RST);
    pose_y_q   = longint'(START_Y_RST);
    pose_hd_q  = START_HD_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset setup, field extremes, zero time, saturation
    d = '0; queue_sample(d);
    d = '{32'h00010000, 32'h0, 32'h00010000, 24'd10000}; queue_sample(d);
    d = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF}; queue_sample(d);
    d = '{32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF}; queue_sample(d);
    d = '{32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 24'd1}; queue_sample(d);
    d = '{32'h00050000, 32'hFFFB0000, 32'h0, 24'd0}; queue_sample(d);
    drain();

    // max gains, x near the positive limit and y near the negative limit, heading near a half turn
    write_reg(REG_LIN_GAIN, 32'h3FFFF);
    write_reg(REG_ANG_GAIN, 32'h3FFFF);
    write_reg(REG_START_X, 32'h7FFF0000);
    write_reg(REG_START_Y, 32'h80010000);
    write_reg(REG_START_HD, 32'h7FFFFFFF);
    write_reg(3'd7, 32'hDEADBEEF);
    d = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000, 24'hFFFFFF}; queue_sample(d);
    d = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 24'hFFFFFF}; queue_sample(d);
    d = '{32'h00100000, 32'hFFF00000, 32'h7FFFFFFF, 24'd500000}; queue_sample(d);
    drain();

    // zero gains, heading at quarter-turn boundaries
    write_reg(REG_LIN_GAIN, 32'h0);
    write_reg(REG_ANG_GAIN, 32'h0);
    write_reg(REG_START_HD, 32'hE0000000);
    d = '{32'h7FFFFFFF, 32'h00020000, 32'h7FFFFFFF, 24'd100000}; queue_sample(d);
    drain();
    write_reg(REG_START_HD, 32'h00000000);
    d = '{32'h00010000, 32'h00030000, 32'h00010000, 24'd2000}; queue_sample(d);
    drain();
    write_reg(REG_START_HD, 32'hFFFFFFFF);
    d = '{32'h00010000, 32'h00010000, 32'h00010000, 24'd1000}; queue_sample(d);
    drain();

    // random phases with fresh settings, one long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_LIN_GAIN, (ph == 0) ? 32'(LIN_GAIN_RST) : 32'($urandom_range(0, 262143)));
      write_reg(REG_ANG_GAIN, (ph == 0) ? 32'(ANG_GAIN_RST) : 32'($urandom_range(0, 262143)));
      write_reg(REG_START_X, rand_word());
      write_reg(REG_START_Y, rand_word());
      write_reg(REG_START_HD, $urandom);
      for (int k = 0; k < 170; k++) queue_sample(rand_sample());
      if (ph == 2) begin
        hold_off_req = 1'b1;
        repeat (2) @(posedge clk);
        hold_off_req = 1'b0;
      end
      drain();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
